// File: hdl/srts_pkg.sv
// Shared types and constants for the stepper ramp table sequencer.
`timescale 1ns / 1ps

package srts_pkg;

    localparam int LEVELS_DEFAULT = 16;

    localparam int ACTION_W   = 3;
    localparam int IDX_W      = 4;
    localparam int WORD_W     = 16;
    localparam int DWELL_W    = 16;
    localparam int LINES_W    = 8;
    localparam int INK_W      = 32;
    localparam int DCOUNT_W   = DWELL_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK        = 3'd0,
        ACT_SETUP       = 3'd1,
        ACT_START       = 3'd2,
        ACT_STOP        = 3'd3,
        ACT_LOAD_LEVEL  = 3'd4,
        ACT_LOAD_INK    = 3'd5,
        ACT_STEP_REQ    = 3'd6,
        ACT_STEP_CANCEL = 3'd7
    } action_t;

    localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_ATTR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MASK   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXCITE_MASK  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_WORD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INK_TRACKING = 3'd4;

    typedef struct packed {
        logic [WORD_W-1:0]  clock_word;
        logic [DWELL_W-1:0] dwell;
        logic [LINES_W-1:0] lines;
    } level_entry_t;

    typedef struct packed {
        logic               reg_write;
        logic [WORD_W-1:0]  reg_word;
        logic               moving;
        logic               move_now;
        logic [INK_W-1:0]   ink_remaining;
        logic [IDX_W-1:0]   speed_level;
    } result_t;

endpackage

// File: hdl/srts_if.sv
// Channel interfaces: command input, result output and configuration write.
`timescale 1ns / 1ps

interface srts_in_if;
    import srts_pkg::*;

    logic               valid;
    logic               ready;
    logic [ACTION_W-1:0] action;
    logic [IDX_W-1:0]   level_index;
    logic [WORD_W-1:0]  level_clock_word;
    logic [DWELL_W-1:0] level_dwell;
    logic [LINES_W-1:0] level_lines;
    logic [INK_W-1:0]   ink_value;
    logic               print_phase;

    modport source (
        output valid, action, level_index, level_clock_word, level_dwell,
               level_lines, ink_value, print_phase,
        input  ready
    );
    modport sink (
        input  valid, action, level_index, level_clock_word, level_dwell,
               level_lines, ink_value, print_phase,
        output ready
    );
endinterface

interface srts_out_if;
    import srts_pkg::*;

    logic              valid;
    logic              ready;
    logic              reg_write;
    logic [WORD_W-1:0] reg_word;
    logic              moving;
    logic              move_now;
    logic [INK_W-1:0]  ink_remaining;
    logic [IDX_W-1:0]  speed_level;

    modport source (
        output valid, reg_write, reg_word, moving, move_now, ink_remaining, speed_level,
        input  ready
    );
    modport sink (
        input  valid, reg_write, reg_word, moving, move_now, ink_remaining, speed_level,
        output ready
    );
endinterface

interface srts_cfg_if;
    import srts_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/stepper_ramp_table_sequencer.sv
// Top level of the table-driven stepper speed ramp sequencer.
`timescale 1ns / 1ps

// Takes one command per clock and returns exactly one result per command, in order.
// The speed table sits in a memory with two registered read ports that is read
// every cycle at the level (and the level above it) that will be current in the
// next cycle, with a bypass for a same-cycle table write, so a tick always finds
// its entries ready and commands never stall on the table. Ready drops only when
// two results are waiting at the output (output register plus skid stage). The
// table needs no clearing pass after reset. Configuration writes are always taken;
// initial_word is accepted, and the motor word starts from its reset value, zero.
module stepper_ramp_table_sequencer #(
    parameter int LEVELS = srts_pkg::LEVELS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    srts_in_if.sink     cmd,
    srts_out_if.source  rsp,
    srts_cfg_if.sink    cfg
);
    import srts_pkg::*;

    localparam int LVL_W = $clog2(LEVELS);
    localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(LEVELS - 1);

    // configuration
    logic [WORD_W-1:0] attr_reg;
    logic [WORD_W-1:0] start_mask_reg;
    logic [WORD_W-1:0] excite_mask_reg;
    logic              ink_track_reg;

    // ramp state
    logic [LVL_W-1:0]    level_reg, level_next;
    logic [DCOUNT_W-1:0] dwell_reg, dwell_next;
    logic                ramp_down_reg, ramp_down_next;
    logic                run_reg, run_next;
    logic                step_req_reg, step_req_next;
    logic [INK_W-1:0]    ink_reg, ink_next;
    logic [WORD_W-1:0]   motor_reg, motor_next;
    logic                wrote;

    // copy of table entry 0 for setup
    logic [WORD_W-1:0]  zero_clock_reg;
    logic [DWELL_W-1:0] zero_dwell_reg;

    level_entry_t cur_entry;
    level_entry_t up_entry;
    level_entry_t wr_entry;
    logic         wr_en;
    logic [LVL_W-1:0] wr_addr;
    logic [LVL_W-1:0] rd_addr_up;
    logic         idx_ok;

    logic         cmd_fire;
    action_t      action;
    logic [INK_W-1:0]    lines_ext;
    logic [INK_W-1:0]    ink_dec;
    logic [DCOUNT_W-1:0] dwell_dec;
    logic [DCOUNT_W-1:0] dwell_inc;
    logic [LVL_W-1:0]    level_up;

    logic    out_ready_int;
    result_t res_item;
    result_t out_item;

    assign cfg.ready = 1'b1;
    assign cmd.ready = out_ready_int;
    assign cmd_fire  = cmd.valid && out_ready_int;
    assign action    = action_t'(cmd.action);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg        <= '0;
            start_mask_reg  <= '0;
            excite_mask_reg <= '0;
            ink_track_reg   <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_MOTOR_ATTR:   attr_reg        <= cfg.data;
                CFG_START_MASK:   start_mask_reg  <= cfg.data;
                CFG_EXCITE_MASK:  excite_mask_reg <= cfg.data;
                CFG_INK_TRACKING: ink_track_reg   <= cfg.data[0];
                CFG_INITIAL_WORD: ;
                default: ;
            endcase
        end
    end

    // table write
    assign idx_ok   = 32'(cmd.level_index) < 32'(LEVELS);
    assign wr_en    = cmd_fire && (action == ACT_LOAD_LEVEL) && idx_ok;
    assign wr_addr  = LVL_W'(cmd.level_index);
    assign wr_entry = '{clock_word: cmd.level_clock_word,
                        dwell:      cmd.level_dwell,
                        lines:      cmd.level_lines};

    // read ahead at the level that will be current next cycle
    assign rd_addr_up = (level_next == LVL_TOP) ? level_next : level_next + LVL_W'(1);

    srts_level_ram #(
        .DEPTH (LEVELS),
        .AW    (LVL_W)
    ) u_level_ram (
        .clk        (clk),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_entry   (wr_entry),
        .rd_addr_a  (level_next),
        .rd_addr_b  (rd_addr_up),
        .rd_entry_a (cur_entry),
        .rd_entry_b (up_entry)
    );

    always_ff @(posedge clk)
    begin
        if (wr_en && cmd.level_index == '0)
        begin
            zero_clock_reg <= cmd.level_clock_word;
            zero_dwell_reg <= cmd.level_dwell;
        end
    end

    assign lines_ext = INK_W'(cur_entry.lines);
    assign ink_dec   = (ink_reg >= lines_ext) ? ink_reg - lines_ext : '0;
    assign dwell_dec = dwell_reg - DCOUNT_W'(1);
    assign dwell_inc = dwell_reg + DCOUNT_W'(1);
    assign level_up  = (level_reg == LVL_TOP) ? level_reg : level_reg + LVL_W'(1);

    always_comb
    begin
        level_next     = level_reg;
        dwell_next     = dwell_reg;
        ramp_down_next = ramp_down_reg;
        run_next       = run_reg;
        step_req_next  = step_req_reg;
        ink_next       = ink_reg;
        motor_next     = motor_reg;
        wrote          = 1'b0;
        if (cmd_fire)
        begin
            case (action)
                ACT_TICK:
                begin
                    wrote      = 1'b1;
                    motor_next = attr_reg | cur_entry.clock_word | start_mask_reg;
                    if (ink_track_reg)
                    begin
                        ink_next = ink_dec;
                    end
                    if (!ramp_down_reg)
                    begin
                        if (dwell_reg != '0)
                        begin
                            dwell_next = dwell_dec;
                            if (dwell_dec == '0)
                            begin
                                level_next = level_up;
                                dwell_next = DCOUNT_W'(up_entry.dwell);
                            end
                        end
                    end
                    else
                    begin
                        dwell_next = dwell_inc;
                        // past the dwell: wrap and step back toward level zero
                        if (dwell_inc > DCOUNT_W'(cur_entry.dwell))
                        begin
                            dwell_next = DCOUNT_W'(1);
                            if (level_reg != '0)
                            begin
                                level_next = level_reg - LVL_W'(1);
                            end
                        end
                    end
                end
                ACT_SETUP:
                begin
                    wrote      = 1'b1;
                    level_next = '0;
                    dwell_next = DCOUNT_W'(zero_dwell_reg);
                    motor_next = attr_reg | zero_clock_reg;
                end
                ACT_START:
                begin
                    ramp_down_next = 1'b0;
                    run_next       = 1'b1;
                end
                ACT_STOP:
                begin
                    wrote          = 1'b1;
                    ramp_down_next = 1'b1;
                    run_next       = 1'b0;
                    motor_next     = motor_reg & ~excite_mask_reg;
                end
                ACT_LOAD_LEVEL: ;
                ACT_LOAD_INK:
                begin
                    ink_next = cmd.ink_value;
                end
                ACT_STEP_REQ:
                begin
                    step_req_next = 1'b1;
                end
                ACT_STEP_CANCEL:
                begin
                    step_req_next = 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= '0;
            dwell_reg     <= '0;
            ramp_down_reg <= 1'b1;
            run_reg       <= 1'b0;
            step_req_reg  <= 1'b0;
            ink_reg       <= '0;
            motor_reg     <= '0;
        end
        else
        begin
            level_reg     <= level_next;
            dwell_reg     <= dwell_next;
            ramp_down_reg <= ramp_down_next;
            run_reg       <= run_next;
            step_req_reg  <= step_req_next;
            ink_reg       <= ink_next;
            motor_reg     <= motor_next;
        end
    end

    assign res_item = '{reg_write:     wrote,
                        reg_word:      motor_next,
                        moving:        run_next,
                        move_now:      run_next && (!cmd.print_phase || step_req_next),
                        ink_remaining: ink_next,
                        speed_level:   IDX_W'(level_next)};

    srts_out_skid u_out_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (out_ready_int),
        .in_item   (res_item),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_item  (out_item)
    );

    assign rsp.reg_write     = out_item.reg_write;
    assign rsp.reg_word      = out_item.reg_word;
    assign rsp.moving        = out_item.moving;
    assign rsp.move_now      = out_item.move_now;
    assign rsp.ink_remaining = out_item.ink_remaining;
    assign rsp.speed_level   = out_item.speed_level;

endmodule

// File: hdl/srts_level_ram.sv
// Speed level table: one write port, two registered read ports with write bypass.
`timescale 1ns / 1ps

module srts_level_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  srts_pkg::level_entry_t wr_entry,
    input  logic [AW-1:0]         rd_addr_a,
    input  logic [AW-1:0]         rd_addr_b,
    output srts_pkg::level_entry_t rd_entry_a,
    output srts_pkg::level_entry_t rd_entry_b
);
    import srts_pkg::*;

    level_entry_t mem [DEPTH];
    level_entry_t rd_a_reg;
    level_entry_t rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        // pass a same-cycle write straight through to the read register
        if (wr_en && wr_addr == rd_addr_a)
        begin
            rd_a_reg <= wr_entry;
        end
        else
        begin
            rd_a_reg <= mem[rd_addr_a];
        end
        if (wr_en && wr_addr == rd_addr_b)
        begin
            rd_b_reg <= wr_entry;
        end
        else
        begin
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_entry_a = rd_a_reg;
    assign rd_entry_b = rd_b_reg;

endmodule

// File: hdl/srts_out_skid.sv
// Result output register with a skid stage so the input side keeps a registered ready.
`timescale 1ns / 1ps

module srts_out_skid (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  srts_pkg::result_t in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output srts_pkg::result_t out_item
);
    import srts_pkg::*;

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t skid_reg;
    logic    in_fire;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = main_valid_reg;
    assign out_item  = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_ready || !main_valid_reg)
        begin
            // main stage frees up: refill from the skid stage first
            main_valid_reg <= skid_valid_reg || in_fire;
            skid_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready || !main_valid_reg)
        begin
            main_reg <= skid_valid_reg ? skid_reg : in_item;
        end
        else if (in_fire)
        begin
            skid_reg <= in_item;
        end
    end

endmodule

// File: dv/stepper_ramp_table_sequencer_tb.sv
// Self-checking testbench for the stepper ramp table sequencer.
`timescale 1ns / 1ps

module stepper_ramp_table_sequencer_tb;
    import srts_pkg::*;

    localparam int LEVELS = LEVELS_DEFAULT;
    localparam int RANDOM_ITEMS = 1200;
    // Index past the end of the register list; the block must ignore it.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd5;

    typedef struct {
        action_t             act;
        logic [IDX_W-1:0]    idx;
        logic [WORD_W-1:0]   word;
        logic [DWELL_W-1:0]  dwell;
        logic [LINES_W-1:0]  lines;
        logic [INK_W-1:0]    ink;
        logic                phase;
    } ramp_cmd_t;

    class ramp_tracker;
        level_entry_t        speed_tab [LEVELS];
        logic [IDX_W-1:0]    lvl;
        logic [DCOUNT_W-1:0] dcount;
        bit                  down;
        bit                  run;
        bit                  step_req;
        logic [INK_W-1:0]    ink;
        logic [WORD_W-1:0]   mword;
        logic [WORD_W-1:0]   attr;
        logic [WORD_W-1:0]   smask;
        logic [WORD_W-1:0]   emask;
        logic [WORD_W-1:0]   iword;
        bit                  ink_on;
        result_t             outcomes [$];
        int                  errors;
        int                  matched;
        int                  top_hits;

        function new();
            lvl      = '0;
            dcount   = '0;
            down     = 1'b1;
            run      = 1'b0;
            step_req = 1'b0;
            ink      = '0;
            mword    = '0;
            attr     = '0;
            smask    = '0;
            emask    = '0;
            iword    = '0;
            ink_on   = 1'b0;
            errors   = 0;
            matched  = 0;
            top_hits = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MOTOR_ATTR:   attr   = data;
                CFG_START_MASK:   smask  = data;
                CFG_EXCITE_MASK:  emask  = data;
                CFG_INITIAL_WORD: iword  = data;
                CFG_INK_TRACKING: ink_on = data[0];
                default: ;
            endcase
        endfunction

        function void tick_ramp();
            logic [INK_W-1:0] lines;
            mword = attr | speed_tab[lvl].clock_word | smask;
            if (ink_on)
            begin
                lines = INK_W'(speed_tab[lvl].lines);
                ink = (ink >= lines) ? ink - lines : '0;
            end
            if (!down)
            begin
                if (dcount != 0)
                begin
                    dcount = dcount - 1'b1;
                    if (dcount == 0)
                    begin
                        if (lvl != IDX_W'(LEVELS - 1))
                            lvl = lvl + 1'b1;
                        dcount = {1'b0, speed_tab[lvl].dwell};
                    end
                end
            end
            else
            begin
                dcount = dcount + 1'b1;
                if (dcount > {1'b0, speed_tab[lvl].dwell})
                begin
                    dcount = DCOUNT_W'(1);
                    if (lvl != 0)
                        lvl = lvl - 1'b1;
                end
            end
        endfunction

        function void take_command(ramp_cmd_t c);
            result_t r;
            bit      wrote;
            wrote = 1'b0;
            case (c.act)
                ACT_TICK:
                begin
                    tick_ramp();
                    wrote = 1'b1;
                    if (lvl == IDX_W'(LEVELS - 1))
                        top_hits++;
                end
                ACT_SETUP:
                begin
                    lvl    = '0;
                    dcount = {1'b0, speed_tab[0].dwell};
                    mword  = attr | speed_tab[0].clock_word;
                    wrote  = 1'b1;
                end
                ACT_START:
                begin
                    down = 1'b0;
                    run  = 1'b1;
                end
                ACT_STOP:
                begin
                    down  = 1'b1;
                    run   = 1'b0;
                    mword = mword & ~emask;
                    wrote = 1'b1;
                end
                ACT_LOAD_LEVEL:
                begin
                    speed_tab[c.idx].clock_word = c.word;
                    speed_tab[c.idx].dwell      = c.dwell;
                    speed_tab[c.idx].lines      = c.lines;
                end
                ACT_LOAD_INK: ink = c.ink;
                ACT_STEP_REQ: step_req = 1'b1;
                default:      step_req = 1'b0;
            endcase
            r.reg_write     = wrote;
            r.reg_word      = mword;
            r.moving        = run;
            r.move_now      = run && (!c.phase || step_req);
            r.ink_remaining = ink;
            r.speed_level   = lvl;
            outcomes.push_back(r);
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        task match_result(result_t got);
            result_t want;
            if (outcomes.size() == 0)
            begin
                report($sformatf("result %h with nothing pending", got));
                return;
            end
            want = outcomes.pop_front();
            matched++;
            if (got.reg_write !== want.reg_write)
                report($sformatf("#%0d reg_write %h, want %h", matched, got.reg_write,
                                 want.reg_write));
            if (got.reg_word !== want.reg_word)
                report($sformatf("#%0d reg_word %h, want %h", matched, got.reg_word,
                                 want.reg_word));
            if (got.moving !== want.moving)
                report($sformatf("#%0d moving %h, want %h", matched, got.moving, want.moving));
            if (got.move_now !== want.move_now)
                report($sformatf("#%0d move_now %h, want %h", matched, got.move_now,
                                 want.move_now));
            if (got.ink_remaining !== want.ink_remaining)
                report($sformatf("#%0d ink_remaining %h, want %h", matched, got.ink_remaining,
                                 want.ink_remaining));
            if (got.speed_level !== want.speed_level)
                report($sformatf("#%0d speed_level %h, want %h", matched, got.speed_level,
                                 want.speed_level));
        endtask
    endclass

    logic clk;
    logic rst_n;
    bit   calm;
    int   sent;
    int   ticks;
    int   reg_writes;

    ramp_tracker tracker;

    srts_in_if  cmd_ch ();
    srts_out_if rsp_ch ();
    srts_cfg_if cfg_ch ();

    stepper_ramp_table_sequencer i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 22);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            tracker.match_result('{rsp_ch.reg_write, rsp_ch.reg_word, rsp_ch.moving,
                                   rsp_ch.move_now, rsp_ch.ink_remaining,
                                   rsp_ch.speed_level});
    end

    function automatic ramp_cmd_t make(action_t a);
        ramp_cmd_t c;
        c.act   = a;
        c.idx   = IDX_W'($urandom_range(0, LEVELS - 1));
        c.word  = WORD_W'($urandom);
        c.dwell = DWELL_W'($urandom);
        c.lines = LINES_W'($urandom);
        c.ink   = $urandom;
        c.phase = 1'($urandom_range(0, 1));
        return c;
    endfunction

    // Mostly short dwells so ramps reach the top, sometimes hold or long.
    function automatic logic [DWELL_W-1:0] pick_dwell();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return DWELL_W'($urandom_range(1, 3));
        else if (r == 7)
            return '0;
        else if (r == 8)
            return DWELL_W'($urandom_range(4, 20));
        return DWELL_W'($urandom);
    endfunction

    task automatic send(ramp_cmd_t c);
        while (!calm && $urandom_range(0, 99) < 22)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid            <= 1'b1;
        cmd_ch.action           <= c.act;
        cmd_ch.level_index      <= c.idx;
        cmd_ch.level_clock_word <= c.word;
        cmd_ch.level_dwell      <= c.dwell;
        cmd_ch.level_lines      <= c.lines;
        cmd_ch.ink_value        <= c.ink;
        cmd_ch.print_phase      <= c.phase;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        tracker.take_command(c);
        sent++;
        if (c.act == ACT_TICK)
            ticks++;
    endtask

    task automatic send_act(action_t a, logic phase);
        ramp_cmd_t c;
        c = make(a);
        c.phase = phase;
        send(c);
    endtask

    task automatic load_level(int idx, logic [DWELL_W-1:0] dwell);
        ramp_cmd_t c;
        c = make(ACT_LOAD_LEVEL);
        c.idx   = IDX_W'(idx);
        c.dwell = dwell;
        send(c);
    endtask

    task automatic load_ink(logic [INK_W-1:0] value);
        ramp_cmd_t c;
        c = make(ACT_LOAD_INK);
        c.ink = value;
        send(c);
    endtask

    // Hold the sender until every result is back, then let the pipeline settle.
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        while (tracker.outcomes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        tracker.set_reg(idx, data);
        reg_writes++;
    endtask

    task automatic program_regs(int round);
        logic [CFG_DATA_W-1:0] fill;
        case (round % 4)
            1:       fill = '0;
            2:       fill = '1;
            default: fill = CFG_DATA_W'($urandom);
        endcase
        cfg_write(CFG_MOTOR_ATTR,   (round % 4 < 3) ? fill : CFG_DATA_W'($urandom));
        cfg_write(CFG_START_MASK,   (round % 4 < 3) ? fill : CFG_DATA_W'($urandom));
        cfg_write(CFG_EXCITE_MASK,  (round % 4 < 3) ? fill : CFG_DATA_W'($urandom));
        cfg_write(CFG_INITIAL_WORD, CFG_DATA_W'($urandom));
        case (round % 4)
            0:       cfg_write(CFG_INK_TRACKING, 16'd1);
            1:       cfg_write(CFG_INK_TRACKING, 16'd0);
            2:       cfg_write(CFG_INK_TRACKING, 16'hFFFF);
            default: cfg_write(CFG_INK_TRACKING, CFG_DATA_W'($urandom));
        endcase
        if (round % 4 == 3)
            cfg_write(CFG_SPARE_IDX, CFG_DATA_W'($urandom));
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic ramp_run();
        int n;
        n = $urandom_range(0, 4);
        repeat (n)
            load_level($urandom_range(0, LEVELS - 1), pick_dwell());
        if ($urandom_range(0, 2) == 0)
            load_ink($urandom_range(0, 1) ? INK_W'($urandom_range(0, 2000)) : INK_W'($urandom));
        send_act(ACT_SETUP, 1'($urandom_range(0, 1)));
        send_act(ACT_START, 1'($urandom_range(0, 1)));
        n = $urandom_range(5, 70);
        repeat (n)
        begin
            case ($urandom_range(0, 15))
                0:       send_act(ACT_STEP_REQ, 1'($urandom_range(0, 1)));
                1:       send_act(ACT_STEP_CANCEL, 1'($urandom_range(0, 1)));
                default: send_act(ACT_TICK, 1'($urandom_range(0, 1)));
            endcase
        end
        send_act(ACT_STOP, 1'($urandom_range(0, 1)));
        n = $urandom_range(0, 40);
        repeat (n)
            send_act(ACT_TICK, 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        int        round;
        int        run_no;
        int        start_count;
        ramp_cmd_t c;

        tracker      = new();
        calm         = 1'b0;
        sent         = 0;
        ticks        = 0;
        reg_writes   = 0;
        rst_n        <= 1'b0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.action           <= ACT_TICK;
        cmd_ch.level_index      <= '0;
        cmd_ch.level_clock_word <= '0;
        cmd_ch.level_dwell      <= '0;
        cmd_ch.level_lines      <= '0;
        cmd_ch.ink_value        <= '0;
        cmd_ch.print_phase      <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_MOTOR_ATTR;
        cfg_ch.data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        round = 0;
        program_regs(round);

        // Fill the whole table before anything reads it.
        for (int i = 0; i < LEVELS; i++)
        begin
            c = make(ACT_LOAD_LEVEL);
            c.idx   = IDX_W'(i);
            c.dwell = (i == LEVELS - 1) ? 16'd2 : 16'd1;
            if (i == 0)
            begin
                c.word  = '0;
                c.lines = '0;
            end
            if (i == LEVELS - 1)
            begin
                c.word  = '1;
                c.lines = '1;
            end
            send(c);
        end

        load_ink('1);
        send_act(ACT_SETUP, 1'b0);
        send_act(ACT_START, 1'b1);
        send_act(ACT_STEP_REQ, 1'b1);
        send_act(ACT_TICK, 1'b1);
        send_act(ACT_STEP_CANCEL, 1'b1);
        send_act(ACT_TICK, 1'b0);
        send_act(ACT_STOP, 1'b0);
        send_act(ACT_TICK, 1'b0);
        send_act(ACT_TICK, 1'b0);
        // Hold at level zero on a zero dwell, and drain ink to zero.
        c = make(ACT_LOAD_LEVEL);
        c.idx   = '0;
        c.dwell = '0;
        c.lines = '1;
        send(c);
        load_ink(INK_W'(5));
        send_act(ACT_SETUP, 1'b1);
        send_act(ACT_START, 1'b0);
        send_act(ACT_TICK, 1'b0);
        send_act(ACT_TICK, 1'b1);
        load_level(0, '1);
        send_act(ACT_STOP, 1'b1);
        load_level(0, 16'd1);

        start_count = sent;
        run_no = 0;
        while (sent - start_count < RANDOM_ITEMS)
        begin
            run_no++;
            calm = (run_no >= 6 && run_no < 10);
            if (run_no % 5 == 0)
            begin
                drain();
                round++;
                program_regs(round);
            end
            else if (run_no % 7 == 0)
                drain();
            if ($urandom_range(0, 9) < 7)
                ramp_run();
            else
            begin
                repeat ($urandom_range(5, 25))
                    send(make(action_t'($urandom_range(0, 7))));
            end
        end

        drain();
        repeat (8) @(posedge clk);
        while (tracker.outcomes.size() != 0)
        begin
            tracker.report("expected result never arrived");
            void'(tracker.outcomes.pop_front());
        end
        $display("Covered %0d commands (%0d ticks, %0d at top speed) and %0d register writes",
                 sent, ticks, tracker.top_hits, reg_writes);
        $display("over %0d register settings; %0d results compared", round + 1,
                 tracker.matched);
        if (tracker.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
